// ----- src/e2c_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and tables for the cube-map coordinate generator.
package e2c_pkg;

  localparam int CORDIC_ITERS = 20;
  localparam int PREC_SHIFT   = 16;
  localparam int CW           = 40;  // CORDIC x/y datapath width
  localparam int AW           = 24;  // binary angle width, pi = 2^20
  localparam int GW           = 30;  // magnitude bits fed to the gain multiply
  localparam int KW           = 17;
  localparam int DW           = 14;  // source dimension register width
  localparam int OW           = 21;  // output coordinate width
  localparam int PX_W         = 22;  // horizontal position, 0..2^21
  localparam int PY_W         = 21;  // vertical position, 0..2^20

  localparam logic [KW-1:0] K_GAIN = 17'd107922;
  localparam logic signed [AW-1:0] ANG_PI      = 24'sd1048576;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 24'sd524288;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 24'sd2097152;
  localparam logic [OW-1:0] OUT_MAX = 21'h1FFFFF;

  localparam int DEFAULT_FACE_SIZE = 256;
  localparam int DEFAULT_FRAC_BITS = 8;

  localparam logic [DW-1:0] SRC_WIDTH_RESET  = 14'd1024;
  localparam logic [DW-1:0] SRC_HEIGHT_RESET = 14'd512;

  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    FACE_FRONT  = 3'd0,
    FACE_RIGHT  = 3'd1,
    FACE_BACK   = 3'd2,
    FACE_LEFT   = 3'd3,
    FACE_TOP    = 3'd4,
    FACE_BOTTOM = 3'd5
  } face_t;

  // round(atan(2^-i) / pi * 2^20)
  function automatic logic signed [AW-1:0] atan_entry(input int idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = 24'sd262144;
      1:  v = 24'sd154753;
      2:  v = 24'sd81767;
      3:  v = 24'sd41506;
      4:  v = 24'sd20834;
      5:  v = 24'sd10427;
      6:  v = 24'sd5215;
      7:  v = 24'sd2608;
      8:  v = 24'sd1304;
      9:  v = 24'sd652;
      10: v = 24'sd326;
      11: v = 24'sd163;
      12: v = 24'sd81;
      13: v = 24'sd41;
      14: v = 24'sd20;
      15: v = 24'sd10;
      16: v = 24'sd5;
      17: v = 24'sd3;
      18: v = 24'sd1;
      19: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AW-1:0] side_yaw(input logic [1:0] f);
    logic signed [AW-1:0] v;
    case (f)
      2'd0: v = '0;
      2'd1: v = ANG_HALF_PI;
      2'd2: v = ANG_PI;
      2'd3: v = -ANG_HALF_PI;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/e2c_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests and source coordinates.
interface e2c_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] face_index;
  logic [7:0] pixel_row;
  logic [7:0] pixel_col;
  modport source (output valid, face_index, pixel_row, pixel_col, input ready);
  modport sink (input valid, face_index, pixel_row, pixel_col, output ready);
endinterface

interface e2c_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] source_x;
  logic [20:0] source_y;
  modport source (output valid, source_x, source_y, input ready);
  modport sink (input valid, source_x, source_y, output ready);
endinterface

// ----- src/equirect_to_cubemap_coords_core.sv -----
`timescale 1ns / 1ps
// Top level: cube-face pixel to equirectangular source coordinate pipeline.
// Takes one pixel per clock while the output is not stalled and maps it to its
// source coordinate through one entry stage, two 21-stage CORDIC pipes
// (one setup stage plus 20 iterations each), an angle fix-up stage, a
// multiply stage and the output register. Any back-pressure on the output
// freezes the whole pipe, so throughput is one item per cycle while the sink
// takes results. source_width/source_height may be changed only while idle.
module equirect_to_cubemap_coords_core #(
  parameter int FACE_SIZE = e2c_pkg::DEFAULT_FACE_SIZE,
  parameter int FRAC_BITS = e2c_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  e2c_in_if.sink                    in_if,
  e2c_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [e2c_pkg::DW-1:0]    cfg_data
);

  localparam int CW  = e2c_pkg::CW;
  localparam int AW  = e2c_pkg::AW;
  localparam int GW  = e2c_pkg::GW;
  localparam int KW  = e2c_pkg::KW;
  localparam int DW  = e2c_pkg::DW;
  localparam int OW  = e2c_pkg::OW;
  localparam int PXW = e2c_pkg::PX_W;
  localparam int PYW = e2c_pkg::PY_W;
  localparam int SW1 = 4 + CW;
  localparam int SW2 = 4 + AW;
  localparam int MXW = PXW + DW;
  localparam int MYW = PYW + DW;
  localparam int PW  = MXW + FRAC_BITS + 1;

  localparam logic signed [CW-1:0] FS_S = CW'(FACE_SIZE);
  localparam logic signed [CW-1:0] PN   = FS_S <<< e2c_pkg::PREC_SHIFT;

  // ---------------- configuration ----------------
  logic [DW-1:0] src_w_r, src_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= e2c_pkg::SRC_WIDTH_RESET;
      src_h_r <= e2c_pkg::SRC_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        e2c_pkg::REG_SRC_WIDTH:  src_w_r <= cfg_data;
        e2c_pkg::REG_SRC_HEIGHT: src_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // ---------------- entry stage ----------------
  logic              in_side;
  logic              in_bad;
  logic signed [CW-1:0] pa_c, pb_c, gsrc, gabs, gpos, gs_c;
  logic signed [CW-1:0] c1x_c, c1y_c;
  logic [GW-1:0]     gmag;
  logic [GW+KW-1:0]  gprod, gsum;
  logic              gneg;

  always_comb begin
    pa_c = (CW'($signed({1'b0, in_if.pixel_col, 1'b0})) - FS_S) <<< e2c_pkg::PREC_SHIFT;
    pb_c = (CW'($signed({1'b0, in_if.pixel_row, 1'b0})) - FS_S) <<< e2c_pkg::PREC_SHIFT;
    in_side = in_if.face_index < e2c_pkg::FACE_TOP;
    in_bad  = in_if.face_index > e2c_pkg::FACE_BOTTOM;
    // companion operand scaled by the CORDIC gain, rounded on the magnitude
    gsrc  = in_side ? pb_c : PN;
    gneg  = gsrc[CW-1];
    gabs  = gneg ? -gsrc : gsrc;
    gmag  = gabs[GW-1:0];
    gprod = gmag * e2c_pkg::K_GAIN;
    gsum  = gprod + (GW+KW)'(32768);
    gpos  = CW'(gsum[GW+KW-1:16]);
    gs_c  = gneg ? -gpos : gpos;
    if (in_side) begin
      c1x_c = PN;
      c1y_c = pa_c;
    end else begin
      c1x_c = pa_c;
      c1y_c = (in_if.face_index == e2c_pkg::FACE_BOTTOM) ? pb_c : -pb_c;
    end
  end

  logic                 s0_vld_r;
  logic [2:0]           s0_face_r;
  logic                 s0_bad_r;
  logic signed [CW-1:0] s0_x_r, s0_y_r, s0_gs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_face_r <= in_if.face_index;
      s0_bad_r  <= in_bad;
      s0_x_r    <= c1x_c;
      s0_y_r    <= c1y_c;
      s0_gs_r   <= gs_c;
    end
  end

  // ---------------- first CORDIC: yaw / plane magnitude ----------------
  logic                 c1_vld;
  logic signed [AW-1:0] c1_ang;
  logic signed [CW-1:0] c1_mag;
  logic [SW1-1:0]       c1_side;

  e2c_cordic #(.SW(SW1)) u_cordic_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s0_vld_r),
    .in_x     (s0_x_r),
    .in_y     (s0_y_r),
    .in_side  ({s0_face_r, s0_bad_r, s0_gs_r}),
    .out_vld  (c1_vld),
    .out_ang  (c1_ang),
    .out_mag  (c1_mag),
    .out_side (c1_side)
  );

  logic [2:0]           c1_face;
  logic                 c1_bad;
  logic signed [CW-1:0] c1_gs;
  logic signed [CW-1:0] c2x_c, c2y_c;

  always_comb begin
    c1_face = c1_side[SW1-1 -: 3];
    c1_bad  = c1_side[CW];
    c1_gs   = c1_side[CW-1:0];
    if (c1_face < e2c_pkg::FACE_TOP) begin
      c2x_c = c1_mag;
      c2y_c = c1_gs;
    end else begin
      c2x_c = c1_gs;
      c2y_c = c1_mag;
    end
  end

  // ---------------- second CORDIC: pitch ----------------
  logic                 c2_vld;
  logic signed [AW-1:0] c2_ang;
  logic signed [CW-1:0] c2_mag;
  logic [SW2-1:0]       c2_side;

  e2c_cordic #(.SW(SW2)) u_cordic_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c1_vld),
    .in_x     (c2x_c),
    .in_y     (c2y_c),
    .in_side  ({c1_face, c1_bad, c1_ang}),
    .out_vld  (c2_vld),
    .out_ang  (c2_ang),
    .out_mag  (c2_mag),
    .out_side (c2_side)
  );

  // ---------------- angle fix-up ----------------
  logic [2:0]           c2_face;
  logic                 c2_bad;
  logic signed [AW-1:0] yaw, pitch, yaw_pos, pitch_pos;
  logic [PXW-1:0]       pos_x_nxt;
  logic [PYW-1:0]       pos_y_nxt;

  always_comb begin
    c2_face = c2_side[SW2-1 -: 3];
    c2_bad  = c2_side[AW];
    yaw     = c2_side[AW-1:0];
    if (c2_face < e2c_pkg::FACE_TOP) begin
      yaw   = yaw + e2c_pkg::side_yaw(c2_face[1:0]);
      pitch = c2_ang;
    end else if (c2_face == e2c_pkg::FACE_BOTTOM) begin
      pitch = e2c_pkg::ANG_HALF_PI - c2_ang;
    end else begin
      pitch = c2_ang - e2c_pkg::ANG_HALF_PI;
    end
    if (pitch > e2c_pkg::ANG_HALF_PI) pitch = e2c_pkg::ANG_HALF_PI;
    if (pitch < -e2c_pkg::ANG_HALF_PI) pitch = -e2c_pkg::ANG_HALF_PI;
    // seam wrap, once each way
    if (yaw > e2c_pkg::ANG_PI) yaw = yaw - e2c_pkg::ANG_TWO_PI;
    if (yaw < -e2c_pkg::ANG_PI) yaw = yaw + e2c_pkg::ANG_TWO_PI;
    yaw_pos   = yaw + e2c_pkg::ANG_PI;
    pitch_pos = pitch + e2c_pkg::ANG_HALF_PI;
    if (yaw_pos < 0) yaw_pos = '0;
    pos_x_nxt = yaw_pos[PXW-1:0];
    pos_y_nxt = pitch_pos[PYW-1:0];
    if (c2_bad) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
    end
  end

  logic           pst_vld_r;
  logic           pst_bad_r;
  logic [PXW-1:0] pos_x_r;
  logic [PYW-1:0] pos_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_vld_r <= 1'b0;
    end else if (en) begin
      pst_vld_r <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pst_bad_r <= c2_bad;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
    end
  end

  // ---------------- scale multiply ----------------
  logic [DW-1:0]  span_w, span_h;
  logic [MXW-1:0] prod_x_nxt;
  logic [MYW-1:0] prod_y_nxt;

  always_comb begin
    span_w     = (src_w_r > DW'(1)) ? src_w_r - DW'(1) : '0;
    span_h     = (src_h_r > DW'(1)) ? src_h_r - DW'(1) : '0;
    prod_x_nxt = pos_x_r * span_w;
    prod_y_nxt = pos_y_r * span_h;
  end

  logic           mul_vld_r;
  logic           mul_bad_r;
  logic [MXW-1:0] prod_x_r;
  logic [MYW-1:0] prod_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= pst_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_bad_r <= pst_bad_r;
      prod_x_r  <= prod_x_nxt;
      prod_y_r  <= prod_y_nxt;
    end
  end

  // ---------------- round, saturate, output register ----------------
  logic [PW-1:0] sh_x, sh_y, q_x, q_y;
  logic [OW-1:0] out_x_nxt, out_y_nxt;

  always_comb begin
    sh_x = (PW'(prod_x_r) << FRAC_BITS) + (PW'(1) << 20);
    sh_y = (PW'(prod_y_r) << FRAC_BITS) + (PW'(1) << 19);
    q_x  = sh_x >> 21;
    q_y  = sh_y >> 20;
    out_x_nxt = (q_x > PW'(e2c_pkg::OUT_MAX)) ? e2c_pkg::OUT_MAX : q_x[OW-1:0];
    out_y_nxt = (q_y > PW'(e2c_pkg::OUT_MAX)) ? e2c_pkg::OUT_MAX : q_y[OW-1:0];
  end

  logic [OW-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.source_x = out_x_r;
  assign out_if.source_y = out_y_r;

  // ---------------- assertions ----------------
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pst_vld_r |-> (pos_x_r <= PXW'(2097152)) && (pos_y_r <= PYW'(1048576)))
    else $error("angle position out of range");

  a_bad_face_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && mul_bad_r |-> (prod_x_r == '0) && (prod_y_r == '0))
    else $error("undefined face produced nonzero coordinate");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && pst_vld_r |=> pst_vld_r && $stable(pos_x_r) && $stable(pos_y_r))
    else $error("pipeline moved during stall");

endmodule

// ----- src/e2c_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: atan2 and gain-scaled magnitude, one stage per iteration.
module e2c_cordic #(
  parameter int SW = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [e2c_pkg::CW-1:0]    in_x,
  input  logic signed [e2c_pkg::CW-1:0]    in_y,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_vld,
  output logic signed [e2c_pkg::AW-1:0]    out_ang,
  output logic signed [e2c_pkg::CW-1:0]    out_mag,
  output logic [SW-1:0]                    out_side
);

  localparam int N = e2c_pkg::CORDIC_ITERS;

  logic                            vld_r  [0:N];
  logic                            zero_r [0:N];
  logic signed [e2c_pkg::CW-1:0]   x_r    [0:N];
  logic signed [e2c_pkg::CW-1:0]   y_r    [0:N];
  logic signed [e2c_pkg::AW-1:0]   a_r    [0:N];
  logic [SW-1:0]                   side_r [0:N];

  logic                            zero_nxt [0:N];
  logic signed [e2c_pkg::CW-1:0]   x_nxt    [0:N];
  logic signed [e2c_pkg::CW-1:0]   y_nxt    [0:N];
  logic signed [e2c_pkg::AW-1:0]   a_nxt    [0:N];

  always_comb begin
    // quarter turn brings x into the right half-plane
    x_nxt[0]    = in_x;
    y_nxt[0]    = in_y;
    a_nxt[0]    = '0;
    zero_nxt[0] = (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x_nxt[0] = in_y;
        y_nxt[0] = -in_x;
        a_nxt[0] = e2c_pkg::ANG_HALF_PI;
      end else begin
        x_nxt[0] = -in_y;
        y_nxt[0] = in_x;
        a_nxt[0] = -e2c_pkg::ANG_HALF_PI;
      end
    end
    for (int k = 0; k < N; k++) begin
      zero_nxt[k+1] = zero_r[k];
      if (y_r[k] >= 0) begin
        x_nxt[k+1] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k+1] = y_r[k] - (x_r[k] >>> k);
        a_nxt[k+1] = a_r[k] + e2c_pkg::atan_entry(k);
      end else begin
        x_nxt[k+1] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k+1] = y_r[k] + (x_r[k] >>> k);
        a_nxt[k+1] = a_r[k] - e2c_pkg::atan_entry(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < N; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 0; k < N; k++) side_r[k+1] <= side_r[k];
      for (int k = 0; k <= N; k++) begin
        x_r[k]    <= x_nxt[k];
        y_r[k]    <= y_nxt[k];
        a_r[k]    <= a_nxt[k];
        zero_r[k] <= zero_nxt[k];
      end
    end
  end

  // zero vector: angle and magnitude both 0
  assign out_vld  = vld_r[N];
  assign out_ang  = zero_r[N] ? '0 : a_r[N];
  assign out_mag  = zero_r[N] ? '0 : x_r[N];
  assign out_side = side_r[N];

endmodule

// ----- verif/equirect_to_cubemap_coords_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for the cube-map coordinate generator: bit-exact prediction and checking.
module equirect_to_cubemap_coords_core_test;

  localparam int NFACE = 256;
  localparam int NFRAC = 8;
  localparam int N_RANDOM = 1600;

  typedef struct {
    logic [20:0] sx;
    logic [20:0] sy;
  } coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = e2c_pkg::REG_SRC_WIDTH;
  logic [e2c_pkg::DW-1:0] cfg_data = '0;

  e2c_in_if in_ch();
  e2c_out_if out_ch();

  equirect_to_cubemap_coords_core uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [e2c_pkg::DW-1:0] pred_width;
  logic [e2c_pkg::DW-1:0] pred_height;

  function automatic longint shr_floor(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint apply_gain(longint v);
    longint m, r;
    m = (v < 0) ? -v : v;
    r = (m * 107922 + 32768) >>> 16;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint vector_angle(longint xs, longint ys, output longint mag);
    longint acc, t, dx, dy;
    acc = 0;
    if (xs == 0 && ys == 0) begin
      mag = 0;
      return 0;
    end
    if (xs < 0) begin
      t = xs;
      if (ys >= 0) begin
        xs = ys; ys = -t; acc = 524288;
      end else begin
        xs = -ys; ys = t; acc = -524288;
      end
    end
    for (int i = 0; i < e2c_pkg::CORDIC_ITERS; i++) begin
      dx = shr_floor(ys, i);
      dy = shr_floor(xs, i);
      if (ys >= 0) begin
        xs += dx; ys -= dy; acc += longint'(e2c_pkg::atan_entry(i));
      end else begin
        xs -= dx; ys += dy; acc -= longint'(e2c_pkg::atan_entry(i));
      end
    end
    mag = xs;
    return acc;
  endfunction

  function automatic logic [20:0] to_pixels(longint pos, logic [e2c_pkg::DW-1:0] dim,
                                            int den_sh);
    longint span, r;
    span = (dim > 1) ? longint'(dim) - 1 : 0;
    if (pos < 0) pos = 0;
    r = (pos * span * (64'd1 << NFRAC) + (64'd1 << (den_sh - 1))) >>> den_sh;
    return (r > 2097151) ? 21'h1FFFFF : r[20:0];
  endfunction

  function automatic coord_t project_pixel(logic [2:0] face, logic [7:0] row, logic [7:0] col);
    coord_t c;
    longint pa, pb, pn, yaw, pitch, mag, junk, dip, fyaw;
    pa = (2 * longint'(col) - NFACE) * 65536;
    pb = (2 * longint'(row) - NFACE) * 65536;
    pn = longint'(NFACE) * 65536;
    if (face > 3'd5) begin
      c.sx = '0; c.sy = '0;
      return c;
    end
    if (face < 3'd4) begin
      fyaw = longint'(e2c_pkg::side_yaw(face[1:0]));
      yaw = vector_angle(pn, pa, mag) + fyaw;
      pitch = vector_angle(mag, apply_gain(pb), junk);
    end else begin
      yaw = vector_angle(pa, (face == e2c_pkg::FACE_BOTTOM) ? pb : -pb, mag);
      dip = vector_angle(apply_gain(pn), mag, junk);
      pitch = (face == e2c_pkg::FACE_BOTTOM) ? 524288 - dip : dip - 524288;
    end
    if (pitch > 524288) pitch = 524288;
    if (pitch < -524288) pitch = -524288;
    if (yaw > 1048576) yaw -= 2097152;
    if (yaw < -1048576) yaw += 2097152;
    c.sx = to_pixels(yaw + 1048576, pred_width, 21);
    c.sy = to_pixels(pitch + 524288, pred_height, 20);
    return c;
  endfunction

  class coord_scoreboard;
    coord_t pending[$];
    int errors;
    int checked;

    function void note_pixel(logic [2:0] f, logic [7:0] r, logic [7:0] c);
      pending.push_back(project_pixel(f, r, c));
    endfunction

    function void check_coord(logic [20:0] sx, logic [20:0] sy);
      coord_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, sx, sy);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sx !== e.sx) begin
        $display("%0t: source_x expected %0d actual %0d", $time, e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $display("%0t: source_y expected %0d actual %0d", $time, e.sy, sy);
        errors++;
      end
    endfunction
  endclass

  coord_scoreboard sb = new();

  int idle_pct = 32;
  int hold_off = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.face_index = '0;
    in_ch.pixel_row = '0;
    in_ch.pixel_col = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_coord(out_ch.source_x, out_ch.source_y);
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // valid stays high into the next item; idle gaps and drain drop it
  task automatic send_pixel(logic [2:0] f, logic [7:0] r, logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.face_index <= f;
    in_ch.pixel_row <= r;
    in_ch.pixel_col <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pixel(f, r, c);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [e2c_pkg::DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == e2c_pkg::REG_SRC_WIDTH) pred_width = val;
    else pred_height = val;
    @(negedge clk);
  endtask

  task automatic random_phase(int count);
    logic [2:0] f;
    for (int i = 0; i < count; i++) begin
      // mostly legal faces, some of the meaningless codes
      f = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_pixel(f, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    pred_width = e2c_pkg::SRC_WIDTH_RESET;
    pred_height = e2c_pkg::SRC_HEIGHT_RESET;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corners, centers, poles, seam, undefined faces
    for (int f = 0; f < 8; f++) begin
      send_pixel(3'(f), 8'd128, 8'd128);
      send_pixel(3'(f), 8'd0, 8'd0);
      send_pixel(3'(f), 8'd255, 8'd255);
    end
    send_pixel(e2c_pkg::FACE_TOP, 8'd128, 8'd0);
    drain();

    // Tiny sizes give zero scale
    write_reg(e2c_pkg::REG_SRC_WIDTH, 14'd1);
    write_reg(e2c_pkg::REG_SRC_HEIGHT, 14'd0);
    random_phase(40);
    drain();

    // Largest sizes drive saturation
    write_reg(e2c_pkg::REG_SRC_WIDTH, 14'h3FFF);
    write_reg(e2c_pkg::REG_SRC_HEIGHT, 14'h3FFF);
    random_phase(150);
    drain();

    write_reg(e2c_pkg::REG_SRC_WIDTH, 14'd2);
    write_reg(e2c_pkg::REG_SRC_HEIGHT, 14'd8192);
    random_phase(150);
    drain();

    write_reg(e2c_pkg::REG_SRC_WIDTH, 14'd8192);
    write_reg(e2c_pkg::REG_SRC_HEIGHT, 14'd2);
    // long stall on the result side while input keeps coming
    hold_off = 200;
    random_phase(200);
    drain();

    write_reg(e2c_pkg::REG_SRC_WIDTH, 14'($urandom_range(8192, 2)));
    write_reg(e2c_pkg::REG_SRC_HEIGHT, 14'($urandom_range(8192, 2)));
    idle_pct = 0;
    random_phase(300);
    idle_pct = 32;
    random_phase(400);
    drain();

    write_reg(e2c_pkg::REG_SRC_WIDTH, 14'($urandom));
    write_reg(e2c_pkg::REG_SRC_HEIGHT, 14'($urandom));
    random_phase(360);
    drain();

    $display("Covered all faces incl. undefined codes, dimension extremes and saturation,");
    $display("%0d results checked under random stalls and a long output hold-off.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/e2c_pkg.sv
src/e2c_ifs.sv
src/e2c_cordic.sv
src/equirect_to_cubemap_coords_core.sv
verif/equirect_to_cubemap_coords_core_test.sv
